>>> sv/lcrsu_pkg.sv
// Shared types, constants and the colour palette for the rain strand updater.
// No dependencies; imported by the top level and lcrsu_fade.
`default_nettype none

package lcrsu_pkg;

	// Width of one cell brightness level
	localparam int LVL_W = 3;

	typedef logic [LVL_W-1:0] level_t;

	// Brightest level: a fresh drop head
	localparam level_t LEVEL_TOP = 3'd6;

	// Draw and threshold width
	localparam int DRAW_W = 7;

	// Red is constant in the green palette
	localparam logic [7:0] RED_CONST = 8'h00;

	// Control result of one strand update
	typedef struct packed {
		logic go;     // strand produces beats
		logic spawn;  // dark strand starts a new drop
	} upd_ctl_t;

	// Palette colour for one level
	typedef struct packed {
		logic [7:0] green;
		logic [7:0] blue;
	} colour_t;

	function automatic colour_t palette(input level_t lvl);
		colour_t c;
		case (lvl)
			3'd0: c = '{green: 8'h00, blue: 8'h00};
			3'd1: c = '{green: 8'h01, blue: 8'h00};
			3'd2: c = '{green: 8'h03, blue: 8'h00};
			3'd3: c = '{green: 8'h0E, blue: 8'h00};
			3'd4: c = '{green: 8'h3B, blue: 8'h00};
			3'd5: c = '{green: 8'h8F, blue: 8'h11};
			default: c = '{green: 8'hFF, blue: 8'h41};
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> sv/led_cube_rain_strand_update_top.sv
// Rain strand updater for an LED cube: accepts a strand and a draw, updates the
// strand in a synchronous level memory and streams its pixels bottom to top.
// Per strand: a memory read, an update that writes back a lit or new-drop
// strand, then one output beat per cell; a new drop emits only its top cell, a
// dark strand that stays dark or one outside the cube (never read) emits nothing.
// A new strand is taken only once the last is through; m_tready stalls beats.
// The level memory holds SIDE*SIDE strands of SIDE cells; a flip-flop per
// strand marks it written, so reset clears the cube at once with no sweep.
// Depends on lcrsu_pkg and lcrsu_fade.
`default_nettype none

module led_cube_rain_strand_update_top #(
	parameter int SIDE = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: spawn_threshold
	input  wire logic        cfg_we,
	input  wire logic [6:0]  cfg_wdata,
	// input beats
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [15:0] s_tdata,   // strand_x[2:0], strand_y[5:3], draw[12:6], zero
	// output beats
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [39:0] m_tdata,   // pixel_x[2:0], pixel_y[5:3], pixel_z[8:6],
	                                    // red[16:9], green[24:17], blue[32:25], zero
	output      logic        m_tlast    // last
);
	import lcrsu_pkg::*;

	localparam int ZW    = (SIDE > 2) ? $clog2(SIDE) : 1;
	localparam int NSTR  = SIDE * SIDE;
	localparam int AW    = $clog2(NSTR);
	localparam int LW    = SIDE * LVL_W;
	localparam int CMPW  = 5;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]        state_q;
	logic [DRAW_W-1:0] thr_q;

	logic [2:0]        in_x;
	logic [2:0]        in_y;
	logic [DRAW_W-1:0] in_draw;
	logic              in_acc;
	logic              in_range;
	logic [AW-1:0]     in_addr;

	logic [2:0]        x_q;
	logic [2:0]        y_q;
	logic [DRAW_W-1:0] draw_q;
	logic [AW-1:0]     addr_q;

	logic [LW-1:0]     mem [NSTR];
	logic [NSTR-1:0]   vld_q;
	logic [LW-1:0]     rdata_q;
	logic              rvld_q;
	logic              rd_en;
	logic              wr_en;

	logic [LW-1:0]     nxt_levels;
	upd_ctl_t          ctl;

	logic [LW-1:0]     levels_q;
	logic [ZW-1:0]     z_q;
	logic              load;
	logic              beat_last;
	level_t            beat_lvl;
	colour_t           beat_col;

	logic              out_vld_q;
	logic [2:0]        out_x_q;
	logic [2:0]        out_y_q;
	logic [2:0]        out_z_q;
	logic [7:0]        out_green_q;
	logic [7:0]        out_blue_q;
	logic              out_last_q;

	// Unpack the input beat
	assign in_x     = s_tdata[2:0];
	assign in_y     = s_tdata[5:3];
	assign in_draw  = s_tdata[12:6];
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign in_range = (CMPW'(in_x) < CMPW'(SIDE)) && (CMPW'(in_y) < CMPW'(SIDE));
	assign in_addr  = AW'(AW'(in_x) * AW'(SIDE) + AW'(in_y));

	assign rd_en = in_acc && in_range;
	assign wr_en = (state_q == ST_CALC) && ctl.go;

	// Hold the spawn threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thr_q <= DRAW_W'(5);
		else if (cfg_we)
			thr_q <= cfg_wdata;
	end

	// Level memory: write back in the update cycle, registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[addr_q] <= nxt_levels;
		if (rd_en)
			rdata_q <= mem[in_addr];
	end

	// Track written strands; unwritten ones read as dark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[addr_q] <= 1'b1;
			if (rd_en)
				rvld_q <= vld_q[in_addr];
		end
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q    <= in_x;
			y_q    <= in_y;
			draw_q <= in_draw;
			addr_q <= in_addr;
		end
	end

	lcrsu_fade #(
		.SIDE(SIDE)
	) u_fade (
		.cur_levels(rdata_q),
		.cur_valid (rvld_q),
		.draw      (draw_q),
		.threshold (thr_q),
		.nxt_levels(nxt_levels),
		.ctl       (ctl)
	);

	// Current beat of the strand
	assign load      = (state_q == ST_EMIT) && (!out_vld_q || m_tready);
	assign beat_lvl  = levels_q[z_q*LVL_W +: LVL_W];
	assign beat_col  = palette(beat_lvl);
	assign beat_last = (z_q == ZW'(SIDE - 1));

	// Sequence: read, update, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			z_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (rd_en)
						state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (ctl.go) begin
						state_q <= ST_EMIT;
						z_q     <= ctl.spawn ? ZW'(SIDE - 1) : '0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (load) begin
						z_q <= z_q + ZW'(1);
						if (beat_last)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Keep the updated strand for emission
	always_ff @(posedge clk) begin
		if (wr_en)
			levels_q <= nxt_levels;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (load)
			out_vld_q <= 1'b1;
		else if (m_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_x_q     <= x_q;
			out_y_q     <= y_q;
			out_z_q     <= 3'(z_q);
			out_green_q <= beat_col.green;
			out_blue_q  <= beat_col.blue;
			out_last_q  <= beat_last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {7'b0, out_blue_q, out_green_q, RED_CONST, out_z_q, out_y_q, out_x_q};

endmodule

`default_nettype wire

>>> sv/lcrsu_fade.sv
// Next-state logic for one strand: fade, drop head shift and new drop start.
// Depends on lcrsu_pkg.
`default_nettype none

module lcrsu_fade #(
	parameter int SIDE = 8
) (
	input  wire logic [SIDE*lcrsu_pkg::LVL_W-1:0]  cur_levels,
	input  wire logic                              cur_valid,
	input  wire logic [lcrsu_pkg::DRAW_W-1:0]      draw,
	input  wire logic [lcrsu_pkg::DRAW_W-1:0]      threshold,
	output      logic [SIDE*lcrsu_pkg::LVL_W-1:0]  nxt_levels,
	output      lcrsu_pkg::upd_ctl_t               ctl
);
	import lcrsu_pkg::*;

	localparam int ZW = (SIDE > 2) ? $clog2(SIDE) : 1;
	localparam int LW = SIDE * LVL_W;

	logic [LW-1:0] lv;
	logic [LW-1:0] faded;
	logic [LW-1:0] spawn_lv;
	logic          lit;
	logic          top_found;
	logic [ZW-1:0] top_pos;

	// Treat a never-written strand as dark
	assign lv = cur_valid ? cur_levels : '0;

	// Find lit cells and the highest drop head
	always_comb begin
		lit       = 1'b0;
		top_found = 1'b0;
		top_pos   = '0;
		for (int z = 0; z < SIDE; z++) begin
			if (lv[z*LVL_W +: LVL_W] != '0)
				lit = 1'b1;
			if (lv[z*LVL_W +: LVL_W] == LEVEL_TOP) begin
				top_found = 1'b1;
				top_pos   = ZW'(z);
			end
		end
	end

	// Fade every cell, then pass the head one cell down
	always_comb begin
		for (int z = 0; z < SIDE; z++) begin
			if (lv[z*LVL_W +: LVL_W] != '0)
				faded[z*LVL_W +: LVL_W] = lv[z*LVL_W +: LVL_W] - level_t'(1);
			else
				faded[z*LVL_W +: LVL_W] = '0;
		end
		for (int z = 0; z < SIDE - 1; z++) begin
			if (top_found && top_pos == ZW'(z + 1))
				faded[z*LVL_W +: LVL_W] = LEVEL_TOP;
		end
	end

	// New drop: only the top cell lights
	always_comb begin
		spawn_lv = '0;
		spawn_lv[(SIDE-1)*LVL_W +: LVL_W] = LEVEL_TOP;
	end

	assign ctl.spawn  = !lit && (draw <= threshold);
	assign ctl.go     = lit || ctl.spawn;
	assign nxt_levels = lit ? faded : spawn_lv;

endmodule

`default_nettype wire

>>> sv/lcrsu_chk.sv
// Port-level checks for the rain strand updater, bound to the top level.
// Depends on led_cube_rain_strand_update_top.
`default_nettype none

module lcrsu_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic        m_tlast
);

	// A stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// No new item while a strand is mid-emission
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input taken mid-strand");

	// A strand's beats follow back to back with the same x and y coordinates
	a_strand: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && m_tdata[5:0] == $past(m_tdata[5:0]))
		else $error("strand beats broken");

	// Red and padding stay zero
	a_red: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[16:9] == 8'h00 && m_tdata[39:33] == 7'h00)
		else $error("red or padding non-zero");

endmodule

bind led_cube_rain_strand_update_top lcrsu_chk u_lcrsu_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);

`default_nettype wire
